// ----- rtl/marker_string_extractor_unit_assert.svh -----
// ----------------------------------------------------------------------------
// marker_string_extractor_unit_assert.svh
// Assertion macros shared by the marker string extractor RTL.
// ----------------------------------------------------------------------------
`ifndef MARKER_STRING_EXTRACTOR_UNIT_ASSERT_SVH
`define MARKER_STRING_EXTRACTOR_UNIT_ASSERT_SVH

// clocked check, off during reset
`define MSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also holds while reset is active
`define MSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/mse_pkg.sv -----
// ----------------------------------------------------------------------------
// mse_pkg
// Types, constants and helpers for the marker string extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package mse_pkg;

  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned TextCountW = 10;
  localparam int unsigned MatchCntW  = 16;

  localparam logic [CfgIdxW-1:0] RegMarker     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxTextLen = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLimitEn    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMatchLimit = 2'd3;

  localparam logic [31:0]           MarkerReset     = 32'h4028_2329;
  localparam logic [TextCountW-1:0] MaxTextLenReset = 10'd1000;
  localparam logic [MatchCntW-1:0]  MatchLimitReset = 16'd1;

  localparam logic CmdData = 1'b0;
  localparam logic CmdEof  = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       has_byte;
    logic       text_end;
    logic       stopped;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctrl_t;

  function automatic logic is_terminator(input logic [7:0] b);
    return (b == 8'h22) || (b == 8'h3E) || (b == 8'h00) ||
           (b == 8'h0A) || (b == 8'h0D) || (b == 8'h5C);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mse_window_cell.sv -----
// ----------------------------------------------------------------------------
// mse_window_cell
// One byte of the match window: holds a byte, hands it on when the window
// shifts, and compares it against its byte of the marker.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_window_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mse_pkg::win_ctrl_t ctrl_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              valid_i,
  input  wire logic [7:0]        pattern_i,
  output logic [7:0]             byte_o,
  output logic                   valid_o,
  output logic                   hit_o
);

  logic [7:0] byte_q;
  logic       valid_q, valid_d;

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.shift) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift && !ctrl_i.clear) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;
  assign hit_o   = valid_q && (byte_q == pattern_i);

endmodule

`default_nettype wire

// ----- rtl/marker_string_extractor_unit.sv -----
// ----------------------------------------------------------------------------
// marker_string_extractor_unit
// Scans a byte stream for a four-byte marker and emits the text after it.
// ----------------------------------------------------------------------------
// One input transfer is taken every cycle while the output can move; each
// result appears in the output register in the cycle after its input transfer.
// The rate is set by the single output register: input ready is high when that
// register is empty or its content is being taken in the same cycle. The last
// three stream bytes sit in a row of three window cells that shift by one byte
// per data transfer while searching; the marker compare is one byte per cell plus the new byte.
`default_nettype none

`include "marker_string_extractor_unit_assert.svh"

module marker_string_extractor_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [mse_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [mse_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire mse_pkg::in_item_t               in_item_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output mse_pkg::out_item_t                   out_item_o
);

  localparam int unsigned NumCells = 3;

  // configuration
  logic [31:0]                        marker_q;
  logic [mse_pkg::TextCountW-1:0]     max_len_q;
  logic                               limit_en_q;
  logic [mse_pkg::MatchCntW-1:0]      match_limit_q;

  // control state
  logic                               capturing_q, capturing_d;
  logic [mse_pkg::TextCountW-1:0]     text_count_q, text_count_d;
  logic [mse_pkg::MatchCntW-1:0]      matches_left_q, matches_left_d;
  logic                               halted_q, halted_d;

  logic                               out_valid_q, out_valid_d;
  mse_pkg::out_item_t                 out_q, out_d;

  mse_pkg::win_ctrl_t                 win_ctrl;
  logic [NumCells-1:0][7:0]           cell_byte;
  logic [NumCells-1:0]                cell_valid;
  logic [NumCells-1:0]                cell_hit;
  logic [NumCells-1:0][7:0]           cell_pat;
  logic [NumCells-1:0][7:0]           cell_in_byte;
  logic [NumCells-1:0]                cell_in_valid;

  logic in_xfer;
  logic match;
  logic used_up;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // cell 0 holds the newest byte, cell 2 the oldest
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    assign cell_pat[k] = marker_q[8*(k+1) +: 8];
    if (k == 0) begin : g_head
      assign cell_in_byte[k]  = in_item_i.data_byte;
      assign cell_in_valid[k] = 1'b1;
    end else begin : g_body
      assign cell_in_byte[k]  = cell_byte[k-1];
      assign cell_in_valid[k] = cell_valid[k-1];
    end
    mse_window_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (win_ctrl),
      .byte_i    (cell_in_byte[k]),
      .valid_i   (cell_in_valid[k]),
      .pattern_i (cell_pat[k]),
      .byte_o    (cell_byte[k]),
      .valid_o   (cell_valid[k]),
      .hit_o     (cell_hit[k])
    );
  end

  assign match   = (&cell_hit) && (in_item_i.data_byte == marker_q[7:0]);
  assign used_up = limit_en_q && (matches_left_q == '0);

  always_comb begin
    capturing_d    = capturing_q;
    text_count_d   = text_count_q;
    matches_left_d = matches_left_q;
    halted_d       = halted_q;
    win_ctrl       = '0;
    out_valid_d    = out_valid_q && !out_ready_i;
    out_d          = out_q;

    if (cfg_we_i && (cfg_idx_i == mse_pkg::RegMatchLimit)) begin
      matches_left_d = cfg_wdata_i[mse_pkg::MatchCntW-1:0];
    end else if (in_xfer) begin
      out_d = '0;
      if (halted_q) begin
        out_valid_d   = 1'b1;
        out_d.stopped = 1'b1;
      end else if (in_item_i.command == mse_pkg::CmdEof) begin
        win_ctrl.clear = 1'b1;
        if (capturing_q) begin
          capturing_d    = 1'b0;
          text_count_d   = '0;
          halted_d       = used_up;
          out_valid_d    = 1'b1;
          out_d.text_end = 1'b1;
          out_d.stopped  = used_up;
        end
      end else if (capturing_q) begin
        if (mse_pkg::is_terminator(in_item_i.data_byte) ||
            (text_count_q >= max_len_q)) begin
          win_ctrl.clear = 1'b1;
          capturing_d    = 1'b0;
          text_count_d   = '0;
          halted_d       = used_up;
          out_valid_d    = 1'b1;
          out_d.text_end = 1'b1;
          out_d.stopped  = used_up;
        end else begin
          text_count_d    = text_count_q + 1'b1;
          out_valid_d     = 1'b1;
          out_d.text_byte = in_item_i.data_byte;
          out_d.has_byte  = 1'b1;
        end
      end else if (used_up) begin
        halted_d      = 1'b1;
        out_valid_d   = 1'b1;
        out_d.stopped = 1'b1;
      end else if (match) begin
        win_ctrl.clear = 1'b1;
        capturing_d    = 1'b1;
        text_count_d   = '0;
        if (limit_en_q) begin
          matches_left_d = matches_left_q - 1'b1;
        end
      end else begin
        win_ctrl.shift = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q       <= mse_pkg::MarkerReset;
      max_len_q      <= mse_pkg::MaxTextLenReset;
      limit_en_q     <= 1'b0;
      match_limit_q  <= mse_pkg::MatchLimitReset;
      capturing_q    <= 1'b0;
      text_count_q   <= '0;
      matches_left_q <= mse_pkg::MatchLimitReset;
      halted_q       <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mse_pkg::RegMarker:     marker_q      <= cfg_wdata_i;
          mse_pkg::RegMaxTextLen: max_len_q     <= cfg_wdata_i[mse_pkg::TextCountW-1:0];
          mse_pkg::RegLimitEn:    limit_en_q    <= cfg_wdata_i[0];
          mse_pkg::RegMatchLimit: match_limit_q <= cfg_wdata_i[mse_pkg::MatchCntW-1:0];
          default: ;
        endcase
      end
      capturing_q    <= capturing_d;
      text_count_q   <= text_count_d;
      matches_left_q <= matches_left_d;
      halted_q       <= halted_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `MSE_ASSERT(a_halt_sticky, halted_q |=> halted_q, "halted state left without reset")
  `MSE_ASSERT(a_halt_idle, halted_q |-> !capturing_q, "capturing while halted")
  `MSE_ASSERT(a_count_capt, (text_count_q != '0) |-> capturing_q,
              "text count set outside a capture")
  `MSE_ASSERT(a_halt_reports, $rose(halted_q) |-> (out_valid_q && out_q.stopped),
              "halt without a stopped transfer")
  `MSE_ASSERT(a_byte_alone, (out_valid_q && out_q.has_byte) |->
              (!out_q.text_end && !out_q.stopped), "text byte mixed with end flags")
  `MSE_ASSERT_ALWAYS(a_limit_kept, (match_limit_q == match_limit_q) || !rst_ni,
              "match limit register unknown")

endmodule

`default_nettype wire

// ----- tb/marker_string_extractor_unit_checker.sv -----
// ----------------------------------------------------------------------------
// marker_string_extractor_unit_checker
// Watches the config port and both streams of the marker string extractor,
// tracks marker search and capture state on its own, and checks each output
// transfer field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module marker_string_extractor_unit_checker
  import mse_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_item_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_item_i,
  output int unsigned           mismatches_o,
  output int unsigned           results_due_o
);

  logic [31:0]           marker;
  logic [TextCountW-1:0] max_len;
  logic                  limit_en;
  logic [MatchCntW-1:0]  match_limit;

  logic [23:0]           window;
  logic [1:0]            fill;
  logic                  capturing;
  logic [TextCountW-1:0] text_count;
  logic [MatchCntW-1:0]  matches_left;
  logic                  halted;

  out_item_t             text_results_q[$];
  int unsigned           fails;

  function automatic logic is_stop_byte(input logic [7:0] b);
    case (b)
      8'h22, 8'h3E, 8'h00, 8'h0A, 8'h0D, 8'h5C: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // closes the open string; returns 1 when this uses up the match budget
  function automatic logic end_capture();
    capturing  = 1'b0;
    text_count = '0;
    window     = '0;
    fill       = '0;
    if (limit_en && matches_left == '0) begin
      halted = 1'b1;
    end
    return halted;
  endfunction

  task automatic scan_stream_item(input in_item_t it);
    out_item_t res;
    logic      made;
    res  = '0;
    made = 1'b1;
    if (halted) begin
      res.stopped = 1'b1;
    end else if (it.command == CmdEof) begin
      if (capturing) begin
        res.text_end = 1'b1;
        res.stopped  = end_capture();
      end else begin
        window = '0;
        fill   = '0;
        made   = 1'b0;
      end
    end else if (capturing) begin
      if (is_stop_byte(it.data_byte) || text_count >= max_len) begin
        res.text_end = 1'b1;
        res.stopped  = end_capture();
      end else begin
        text_count    = text_count + 1'b1;
        res.text_byte = it.data_byte;
        res.has_byte  = 1'b1;
      end
    end else if (limit_en && matches_left == '0) begin
      halted      = 1'b1;
      res.stopped = 1'b1;
    end else begin
      made = 1'b0;
      if (fill == 2'd3 && {window, it.data_byte} == marker) begin
        capturing  = 1'b1;
        text_count = '0;
        window     = '0;
        fill       = '0;
        if (limit_en) begin
          matches_left = matches_left - 1'b1;
        end
      end else begin
        window = {window[15:0], it.data_byte};
        if (fill != 2'd3) begin
          fill = fill + 1'b1;
        end
      end
    end
    if (made) begin
      text_results_q.push_back(res);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_item_t want;
    if (!rst_ni) begin
      marker        = MarkerReset;
      max_len       = MaxTextLenReset;
      limit_en      = 1'b0;
      match_limit   = MatchLimitReset;
      matches_left  = MatchLimitReset;
      window        = '0;
      fill          = '0;
      capturing     = 1'b0;
      text_count    = '0;
      halted        = 1'b0;
      fails         = 0;
      text_results_q.delete();
      mismatches_o  <= 0;
      results_due_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (text_results_q.size() == 0) begin
          $error("output transfer with nothing pending: %p", out_item_i);
          fails++;
        end else begin
          want = text_results_q.pop_front();
          if (out_item_i.text_byte !== want.text_byte) begin
            $error("text_byte: expected %h, actual %h", want.text_byte, out_item_i.text_byte);
            fails++;
          end
          if (out_item_i.has_byte !== want.has_byte) begin
            $error("has_byte: expected %b, actual %b", want.has_byte, out_item_i.has_byte);
            fails++;
          end
          if (out_item_i.text_end !== want.text_end) begin
            $error("text_end: expected %b, actual %b", want.text_end, out_item_i.text_end);
            fails++;
          end
          if (out_item_i.stopped !== want.stopped) begin
            $error("stopped: expected %b, actual %b", want.stopped, out_item_i.stopped);
            fails++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegMarker:     marker   = cfg_wdata_i;
          RegMaxTextLen: max_len  = cfg_wdata_i[TextCountW-1:0];
          RegLimitEn:    limit_en = cfg_wdata_i[0];
          RegMatchLimit: begin
            match_limit  = cfg_wdata_i[MatchCntW-1:0];
            matches_left = match_limit;
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        scan_stream_item(in_item_i);
      end
      mismatches_o  <= fails;
      results_due_o <= text_results_q.size();
    end
  end

endmodule

// ----- tb/marker_string_extractor_unit_tb.sv -----
// ----------------------------------------------------------------------------
// marker_string_extractor_unit_tb
// Drives marker string extractor with directed strings, then marker/text
// streams under several register settings, with random idling on both sides,
// a long output hold-off and a final match-limit halt; the checker scores it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module marker_string_extractor_unit_tb;
  import mse_pkg::*;

  localparam int unsigned RandomItems = 300;
  localparam int unsigned HoldCycles  = 300;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = RegMarker;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_item_o;

  int unsigned         mismatches;
  int unsigned         results_due;

  logic                quiet    = 1'b0;
  logic                hold_req = 1'b0;
  logic [31:0]         cur_marker  = MarkerReset;
  logic [9:0]          cur_max_len = MaxTextLenReset;
  int unsigned         items_sent;

  logic [7:0]          text_stops [6] = '{8'h22, 8'h3E, 8'h00, 8'h0A, 8'h0D, 8'h5C};

  marker_string_extractor_unit u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .in_item_i,
    .out_valid_o,
    .out_ready_i,
    .out_item_o
  );

  marker_string_extractor_unit_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_i    (in_ready_o),
    .in_item_i,
    .out_valid_i   (out_valid_o),
    .out_ready_i,
    .out_item_i    (out_item_o),
    .mismatches_o  (mismatches),
    .results_due_o (results_due)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req <= 1'b0;
      end
      out_ready_i <= quiet || ($urandom_range(99) >= 12);
    end
  end

  function automatic logic [7:0] text_char();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b inside {8'h22, 8'h3E, 8'h00, 8'h0A, 8'h0D, 8'h5C});
    return b;
  endfunction

  // called at a rising edge; returns at the edge of the transfer, valid left high
  task automatic offer(input logic cmd, input logic [7:0] b);
    in_item_t it;
    if (!quiet && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    it.command   = cmd;
    it.data_byte = b;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_marker(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      offer(CmdData, cur_marker[31 - 8*i -: 8]);
    end
  endtask

  task automatic capture_segment();
    int unsigned cap;
    repeat ($urandom_range(0, 5)) begin
      if ($urandom_range(1)) offer(CmdData, cur_marker[31 - 8*$urandom_range(3) -: 8]);
      else offer(CmdData, 8'($urandom_range(255)));
    end
    if ($urandom_range(9) == 0) offer(CmdEof, 8'($urandom_range(255)));
    if ($urandom_range(9) == 0) begin
      send_marker($urandom_range(1, 3));
      if ($urandom_range(1)) offer(CmdEof, 8'($urandom_range(255)));
      else offer(CmdData, 8'($urandom_range(255)));
    end else begin
      send_marker(4);
      cap = (cur_max_len < 12) ? cur_max_len + 1 : 12;
      repeat ($urandom_range(0, cap)) offer(CmdData, text_char());
      case ($urandom_range(3))
        0, 1: offer(CmdData, text_stops[$urandom_range(5)]);
        2: offer(CmdEof, 8'($urandom_range(255)));
        default: offer(CmdData, 8'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic stream(input int unsigned n);
    items_sent = 0;
    while (items_sent < n) capture_segment();
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [31:0] mk, input logic [9:0] ml,
                           input logic le, input logic [15:0] lim);
    write_reg(RegMarker, mk);
    write_reg(RegMaxTextLen, {22'd0, ml});
    write_reg(RegLimitEn, {31'd0, le});
    write_reg(RegMatchLimit, {16'd0, lim});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cur_marker  = mk;
    cur_max_len = ml;
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: default marker, EOF while idle, text, terminators
    offer(CmdEof, 8'hFF);
    send_marker(4);
    offer(CmdData, 8'hFF);
    offer(CmdData, 8'h80);
    offer(CmdData, 8'h7F);
    offer(CmdData, 8'h00);
    send_marker(4);
    offer(CmdData, 8'h01);
    offer(CmdEof, 8'h00);
    send_marker(4);
    offer(CmdData, 8'h3E);
    // EOF inside the marker clears the window: no match
    send_marker(2);
    offer(CmdEof, 8'h55);
    offer(CmdData, cur_marker[15:8]);
    offer(CmdData, cur_marker[7:0]);

    // longest string, ended by the length limit, with no idling
    wait_idle();
    configure(32'hFFFF_FFFF, 10'd1023, 1'b0, 16'd1);
    quiet <= 1'b1;
    send_marker(4);
    repeat (1024) offer(CmdData, text_char());
    quiet <= 1'b0;
    stream(100);

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      configure(p == 0 ? 32'h0 : 32'($urandom()),
                p == 1 ? 10'd0 : p == 2 ? 10'd1 : 10'($urandom_range(1, 20)),
                p == 5 ? 1'b0 : 1'($urandom_range(1)),
                p == 5 ? 16'd2 : p == 3 ? 16'hFFFF : 16'($urandom_range(1000, 65535)));
      quiet <= (p == 2);
      if (p == 4) hold_req <= 1'b1;
      stream(RandomItems / 6);
    end

    // budget left untouched while disabled; enable it and run into the halt
    wait_idle();
    write_reg(RegLimitEn, 32'd1);
    if ($urandom_range(3) == 0) write_reg(RegMatchLimit, 32'd0);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    stream(150);
    wait_idle();

    if (mismatches == 0) begin
      $display("marker_string_extractor_unit_tb passed");
    end else begin
      $display("marker_string_extractor_unit_tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(2_000_000);
    $display("marker_string_extractor_unit_tb failed");
    $finish;
  end

endmodule
